@@ sv/mie_pkg.sv @@
// Shared types, operation codes and constants for the MIPS integer execute block.
package mie_pkg;

	// Data memory geometry: four byte lanes, one byte per lane per row.
	localparam int DMEM_BYTES = 16384;
	localparam int DMEM_AW    = $clog2(DMEM_BYTES);
	localparam int DMEM_ROWS  = DMEM_BYTES / 4;
	localparam int DMEM_RW    = DMEM_AW - 2;

	localparam int RF_DEPTH = 32;

	localparam logic [31:0] PC_RESET    = 32'h0400_0000;
	localparam logic [31:0] SYS_PRINT_INT  = 32'd1;
	localparam logic [31:0] SYS_EXIT       = 32'd10;
	localparam logic [31:0] SYS_PRINT_CHAR = 32'd11;

	localparam logic [4:0] REG_ZERO = 5'd0;
	localparam logic [4:0] REG_V0   = 5'd2;
	localparam logic [4:0] REG_A0   = 5'd4;
	localparam logic [4:0] REG_RA   = 5'd31;

	typedef enum logic [4:0] {
		OP_ADD     = 5'd0,
		OP_ADDU    = 5'd1,
		OP_ADDI    = 5'd2,
		OP_ADDIU   = 5'd3,
		OP_SUB     = 5'd4,
		OP_OR      = 5'd5,
		OP_ORI     = 5'd6,
		OP_SLL     = 5'd7,
		OP_SRL     = 5'd8,
		OP_AND     = 5'd9,
		OP_ANDI    = 5'd10,
		OP_XORI    = 5'd11,
		OP_XOR     = 5'd12,
		OP_LW      = 5'd13,
		OP_SW      = 5'd14,
		OP_SB      = 5'd15,
		OP_LB      = 5'd16,
		OP_LH      = 5'd17,
		OP_SH      = 5'd18,
		OP_BEQ     = 5'd19,
		OP_BNE     = 5'd20,
		OP_SLT     = 5'd21,
		OP_SLTI    = 5'd22,
		OP_J       = 5'd23,
		OP_JR      = 5'd24,
		OP_JAL     = 5'd25,
		OP_LUI     = 5'd26,
		OP_SYSCALL = 5'd27
	} op_t;

	typedef enum logic [1:0] {
		CON_NONE = 2'd0,
		CON_INT  = 2'd1,
		CON_CHAR = 2'd2
	} con_t;

	// Access size, coded as the offset of the last byte touched.
	typedef enum logic [1:0] {
		SZ_BYTE = 2'd0,
		SZ_HALF = 2'd1,
		SZ_WORD = 2'd3
	} sz_t;

	typedef enum logic [1:0] {
		LD_NONE = 2'd0,
		LD_WORD = 2'd1,
		LD_BYTE = 2'd2,
		LD_HALF = 2'd3
	} ld_t;

	typedef struct packed {
		logic [4:0]  func;
		logic [4:0]  src_reg;
		logic [4:0]  tgt_reg;
		logic [4:0]  dst_reg;
		logic [4:0]  shift_amount;
		logic [15:0] immediate;
		logic [25:0] jump_target;
	} instr_t;

	typedef struct packed {
		logic [31:0] next_pc;
		logic        reg_written;
		logic [4:0]  written_index;
		logic [31:0] written_value;
		logic        overflow;
		logic [1:0]  console_kind;
		logic [31:0] console_value;
		logic        halted;
	} result_t;

endpackage

@@ sv/mips_integer_execute.sv @@
// Top level of the MIPS integer execute block: operand read, execute, memory and writeback.
//
//   channel   | dir | payload           | handshake
//   ----------+-----+-------------------+----------------------------------------
//   instr     | in  | instr_t (67 bits) | instr_valid / instr_stall
//   result    | out | result_t          | result_valid / result_stall
//   cfg       | in  | 32-bit start_pc   | cfg_we, written at the clock edge
//
// One word is taken per cycle while instr_stall is low. Each word passes register file read,
// execute with data memory access, then writeback into a four-entry result queue, whose
// head drives result and result_valid. The program counter and halt flag
// chain through the execute stage, one word per cycle. Reset clears the pipeline, the
// register file valid bits and the halt flag and loads the program counter; the data memory
// is not cleared. instr_stall rises when the queued and in-flight results would fill the queue.
module mips_integer_execute (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             instr_valid,
	output logic             instr_stall,
	input  mie_pkg::instr_t  instr,
	output logic             result_valid,
	input  logic             result_stall,
	output mie_pkg::result_t result,
	input  logic             cfg_we,
	input  logic [31:0]      cfg_wdata
);
	import mie_pkg::*;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// ---------------------------------------------------------------- accept and read
	logic        instr_accept;
	logic [4:0]  rd_addr_a;
	logic [4:0]  rd_addr_b;
	logic [31:0] rf_a;
	logic [31:0] rf_b;

	assign instr_accept = instr_valid && !instr_stall;

	// A syscall reads its code from v0 and its argument from a0 on the two ports.
	assign rd_addr_a = (instr.func == OP_SYSCALL) ? REG_V0 : instr.src_reg;
	assign rd_addr_b = (instr.func == OP_SYSCALL) ? REG_A0 : instr.tgt_reg;

	// Stage 1 payload, captured with the register file read.
	logic        valid_s1;
	logic [4:0]  op_s1;
	logic [4:0]  ra_s1;
	logic [4:0]  rb_s1;
	logic [4:0]  tgt_s1;
	logic [4:0]  dst_s1;
	logic [4:0]  shamt_s1;
	logic [15:0] imm_s1;
	logic [25:0] jt_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= instr_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (instr_accept) begin
			op_s1    <= instr.func;
			ra_s1    <= rd_addr_a;
			rb_s1    <= rd_addr_b;
			tgt_s1   <= instr.tgt_reg;
			dst_s1   <= instr.dst_reg;
			shamt_s1 <= instr.shift_amount;
			imm_s1   <= instr.immediate;
			jt_s1    <= instr.jump_target;
		end
	end

	// Stage 2 signals used for forwarding and writeback.
	logic        valid_s2;
	logic [31:0] npc_s2;
	logic        wr_s2;
	logic [4:0]  widx_s2;
	logic [31:0] alu_s2;
	logic        ovf_s2;
	logic [1:0]  ck_s2;
	logic [31:0] cv_s2;
	logic        halted_s2;
	ld_t         ld_s2;
	logic [31:0] dm_rdata;
	logic [31:0] wb_val;
	logic        wb_we;

	mie_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.ra_addr (rd_addr_a),
		.rb_addr (rd_addr_b),
		.ra_data (rf_a),
		.rb_data (rf_b),
		.we      (wb_we),
		.waddr   (widx_s2),
		.wdata   (wb_val)
	);

	// ---------------------------------------------------------------- execute
	logic [31:0] pc_q;
	logic        halt_q;
	logic [31:0] opa;
	logic [31:0] opb;
	logic [31:0] simm;
	logic [31:0] zimm;
	logic [31:0] pc4;
	logic [31:0] sum_ab;
	logic [31:0] sum_ai;
	logic [31:0] br_tgt;
	logic [31:0] jmp_tgt;
	logic [31:0] npc;
	logic        wr;
	logic [4:0]  widx;
	logic [31:0] val;
	logic        ovf;
	logic [1:0]  ck;
	logic [31:0] cv;
	logic        st_en;
	sz_t         st_sz;
	ld_t         ld;
	logic        halt_set;
	logic        live;

	// The word one stage ahead writes back only after this word read the register
	// file, so its result is forwarded here. Older writes are covered by the
	// register file's write-through read.
	assign opa = (valid_s2 && wr_s2 && (widx_s2 == ra_s1)) ? wb_val : rf_a;
	assign opb = (valid_s2 && wr_s2 && (widx_s2 == rb_s1)) ? wb_val : rf_b;

	assign live    = valid_s1 && !halt_q;
	assign simm    = {{16{imm_s1[15]}}, imm_s1};
	assign zimm    = {16'd0, imm_s1};
	assign pc4     = pc_q + 32'd4;
	assign sum_ab  = opa + opb;
	assign sum_ai  = opa + simm;
	assign br_tgt  = pc4 + {simm[29:0], 2'b00};
	assign jmp_tgt = {pc4[31:28], jt_s1, 2'b00};

	always_comb begin
		npc      = pc4;
		wr       = 1'b0;
		widx     = dst_s1;
		val      = 32'd0;
		ovf      = 1'b0;
		ck       = CON_NONE;
		cv       = 32'd0;
		st_en    = 1'b0;
		st_sz    = SZ_WORD;
		ld       = LD_NONE;
		halt_set = 1'b0;
		case (op_s1)
			OP_ADD: begin
				val = sum_ab;
				wr  = 1'b1;
				ovf = ~(opa[31] ^ opb[31]) & (opa[31] ^ sum_ab[31]);
			end
			OP_ADDU: begin
				val = sum_ab;
				wr  = 1'b1;
			end
			OP_ADDI, OP_ADDIU: begin
				val  = sum_ai;
				wr   = 1'b1;
				widx = tgt_s1;
			end
			OP_SUB: begin
				val = opa - opb;
				wr  = 1'b1;
			end
			OP_OR: begin
				val = opa | opb;
				wr  = 1'b1;
			end
			OP_ORI: begin
				val  = opa | zimm;
				wr   = 1'b1;
				widx = tgt_s1;
			end
			OP_SLL: begin
				val = opb << shamt_s1;
				wr  = 1'b1;
			end
			OP_SRL: begin
				val = opb >> shamt_s1;
				wr  = 1'b1;
			end
			OP_AND: begin
				val = opa & opb;
				wr  = 1'b1;
			end
			OP_ANDI: begin
				val  = opa & zimm;
				wr   = 1'b1;
				widx = tgt_s1;
			end
			OP_XORI: begin
				val  = opa ^ zimm;
				wr   = 1'b1;
				widx = tgt_s1;
			end
			OP_XOR: begin
				val = opa ^ opb;
				wr  = 1'b1;
			end
			OP_LW: begin
				ld   = LD_WORD;
				wr   = 1'b1;
				widx = tgt_s1;
			end
			OP_LB: begin
				ld   = LD_BYTE;
				wr   = 1'b1;
				widx = tgt_s1;
			end
			OP_LH: begin
				ld   = LD_HALF;
				wr   = 1'b1;
				widx = tgt_s1;
			end
			OP_SW: begin
				st_en = 1'b1;
				st_sz = SZ_WORD;
			end
			OP_SH: begin
				st_en = 1'b1;
				st_sz = SZ_HALF;
			end
			OP_SB: begin
				st_en = 1'b1;
				st_sz = SZ_BYTE;
			end
			OP_BEQ: begin
				if (opa == opb) begin
					npc = br_tgt;
				end
			end
			OP_BNE: begin
				if (opa != opb) begin
					npc = br_tgt;
				end
			end
			OP_SLT: begin
				val = {31'd0, ($signed(opa) < $signed(opb))};
				wr  = 1'b1;
			end
			OP_SLTI: begin
				val  = {31'd0, ($signed(opa) < $signed(simm))};
				wr   = 1'b1;
				widx = tgt_s1;
			end
			OP_J: begin
				npc = jmp_tgt;
			end
			OP_JR: begin
				npc = opa;
			end
			OP_JAL: begin
				val  = pc4;
				wr   = 1'b1;
				widx = REG_RA;
				npc  = jmp_tgt;
			end
			OP_LUI: begin
				val  = {imm_s1, 16'd0};
				wr   = 1'b1;
				widx = tgt_s1;
			end
			OP_SYSCALL: begin
				// Operand A holds v0 (the code) and operand B holds a0.
				if (opa == SYS_PRINT_INT) begin
					ck = CON_INT;
					cv = opb;
				end else if (opa == SYS_PRINT_CHAR) begin
					ck = CON_CHAR;
					cv = {24'd0, opb[7:0]};
				end else if (opa == SYS_EXIT) begin
					halt_set = 1'b1;
				end
			end
			default: begin
			end
		endcase

		// Register zero is never written; a dropped write reports nothing.
		if (!wr || (widx == REG_ZERO)) begin
			wr   = 1'b0;
			widx = REG_ZERO;
			val  = 32'd0;
			ld   = LD_NONE;
		end

		// Once halted, a word changes nothing and reports the held program counter.
		if (halt_q) begin
			npc   = pc_q;
			wr    = 1'b0;
			widx  = REG_ZERO;
			val   = 32'd0;
			ovf   = 1'b0;
			ck    = CON_NONE;
			cv    = 32'd0;
			st_en = 1'b0;
			ld    = LD_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= PC_RESET;
			halt_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				pc_q <= cfg_wdata;
			end else if (valid_s1) begin
				pc_q <= npc;
			end
			if (live && halt_set) begin
				halt_q <= 1'b1;
			end
		end
	end

	// Stores and load reads both happen here, so a load always sees every older store.
	mie_dmem u_dmem (
		.clk   (clk),
		.addr  (sum_ai[DMEM_AW-1:0]),
		.we    (live && st_en),
		.size  (st_sz),
		.wdata (opb),
		.rdata (dm_rdata)
	);

	// ---------------------------------------------------------------- writeback
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			npc_s2    <= npc;
			wr_s2     <= wr;
			widx_s2   <= widx;
			alu_s2    <= val;
			ovf_s2    <= ovf;
			ck_s2     <= ck;
			cv_s2     <= cv;
			halted_s2 <= halt_q || (live && halt_set);
			ld_s2     <= ld;
		end
	end

	always_comb begin
		case (ld_s2)
			LD_WORD: wb_val = dm_rdata;
			LD_BYTE: wb_val = {{24{dm_rdata[7]}}, dm_rdata[7:0]};
			LD_HALF: wb_val = {{16{dm_rdata[15]}}, dm_rdata[15:0]};
			default: wb_val = alu_s2;
		endcase
	end

	assign wb_we = valid_s2 && wr_s2;

	// ---------------------------------------------------------------- result queue
	result_t          q_mem_q [QDEPTH];
	logic [QAW-1:0]   q_wr_q;
	logic [QAW-1:0]   q_rd_q;
	logic [QAW:0]     q_cnt_q;
	logic             q_push;
	logic             q_pop;
	result_t          q_in;
	logic [QAW:0]     q_pending;

	assign q_in = '{
		next_pc:       npc_s2,
		reg_written:   wr_s2,
		written_index: widx_s2,
		written_value: wb_val,
		overflow:      ovf_s2,
		console_kind:  ck_s2,
		console_value: cv_s2,
		halted:        halted_s2
	};

	assign q_push = valid_s2;
	assign q_pop  = result_valid && !result_stall;

	// Every word already in flight is guaranteed a queue slot.
	assign q_pending   = q_cnt_q + {{QAW{1'b0}}, valid_s1} + {{QAW{1'b0}}, valid_s2};
	assign instr_stall = (q_pending >= (QAW+1)'(QDEPTH));

	always_ff @(posedge clk) begin
		if (q_push) begin
			q_mem_q[q_wr_q] <= q_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wr_q  <= '0;
			q_rd_q  <= '0;
			q_cnt_q <= '0;
		end else begin
			if (q_push) begin
				q_wr_q <= q_wr_q + 1'b1;
			end
			if (q_pop) begin
				q_rd_q <= q_rd_q + 1'b1;
			end
			q_cnt_q <= q_cnt_q + {{QAW{1'b0}}, q_push} - {{QAW{1'b0}}, q_pop};
		end
	end

	assign result_valid = (q_cnt_q != '0);
	assign result       = q_mem_q[q_rd_q];

endmodule

@@ sv/mie_regfile.sv @@
// Register file: 32 x 32 memory, two registered read ports, one write port, reset via valid bits.
module mie_regfile (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [4:0]  ra_addr,
	input  logic [4:0]  rb_addr,
	output logic [31:0] ra_data,
	output logic [31:0] rb_data,
	input  logic        we,
	input  logic [4:0]  waddr,
	input  logic [31:0] wdata
);
	import mie_pkg::*;

	logic [31:0]         mem_q [RF_DEPTH];
	logic [RF_DEPTH-1:0] vld_q;
	logic [31:0]         ra_data_q;
	logic [31:0]         rb_data_q;
	logic                ra_vld_q;
	logic                rb_vld_q;
	logic                ra_thru;
	logic                rb_thru;

	// A read of the entry being written returns the new value.
	assign ra_thru = we && (waddr == ra_addr);
	assign rb_thru = we && (waddr == rb_addr);

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		ra_data_q <= ra_thru ? wdata : mem_q[ra_addr];
		rb_data_q <= rb_thru ? wdata : mem_q[rb_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			ra_vld_q <= 1'b0;
			rb_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			ra_vld_q <= ra_thru || vld_q[ra_addr];
			rb_vld_q <= rb_thru || vld_q[rb_addr];
		end
	end

	// Entries not written since reset read as zero.
	assign ra_data = ra_vld_q ? ra_data_q : 32'd0;
	assign rb_data = rb_vld_q ? rb_data_q : 32'd0;

endmodule

@@ sv/mie_dmem.sv @@
// Data memory: four byte-lane banks with unaligned little-endian access and registered read.
module mie_dmem (
	input  logic                        clk,
	input  logic [mie_pkg::DMEM_AW-1:0] addr,
	input  logic                        we,
	input  mie_pkg::sz_t                size,
	input  logic [31:0]                 wdata,
	output logic [31:0]                 rdata
);
	import mie_pkg::*;

	logic [7:0] lane_rd_q [4];
	logic [1:0] off_q;

	for (genvar l = 0; l < 4; l++) begin : g_lane
		logic [7:0]         bank_q [DMEM_ROWS];
		logic [1:0]         lane_ofs;
		logic [DMEM_RW-1:0] row;
		logic               lane_we;
		logic [7:0]         wbyte;

		// Lanes below the start offset hold bytes of the next row, wrapping at the top.
		assign lane_ofs = 2'(l) - addr[1:0];
		assign row      = addr[DMEM_AW-1:2]
			+ {{(DMEM_RW-1){1'b0}}, (2'(l) < addr[1:0])};
		assign lane_we  = we && (lane_ofs <= size);
		assign wbyte    = wdata[{lane_ofs, 3'b000} +: 8];

		always_ff @(posedge clk) begin
			if (lane_we) begin
				bank_q[row] <= wbyte;
			end
			lane_rd_q[l] <= bank_q[row];
		end
	end

	always_ff @(posedge clk) begin
		off_q <= addr[1:0];
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			rdata[8*i +: 8] = lane_rd_q[2'(off_q + 2'(i))];
		end
	end

endmodule

@@ sv/mie_checker.sv @@
// Port-level checker for the MIPS integer execute block, bound to the top level.
module mie_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             result_valid,
	input logic             result_stall,
	input mie_pkg::result_t result
);
	import mie_pkg::*;

	logic seen_halt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_halt_q <= 1'b0;
		end else if (result_valid && !result_stall && result.halted) begin
			seen_halt_q <= 1'b1;
		end
	end

	// A waiting result word holds until it is taken.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	// After a halt has been delivered, later words have no effect.
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && seen_halt_q |-> result.halted && !result.reg_written
			&& (result.console_kind == CON_NONE) && !result.overflow)
		else $error("word after halt had an effect");

	// Register zero is never reported as written.
	a_no_reg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.reg_written |-> (result.written_index != REG_ZERO))
		else $error("write to register zero reported");

	// Without a write, index and value read zero.
	a_idle_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.reg_written |->
			(result.written_index == REG_ZERO) && (result.written_value == 32'd0))
		else $error("write fields set without a write");

endmodule

bind mips_integer_execute mie_checker u_mie_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
